### sv/chc_pkg.sv
package chc_pkg;

  localparam int unsigned FracBits = 8;
  localparam int unsigned CoordW   = 24;

  // radius fields are fixed at 16 bits
  localparam int unsigned RadW     = 16;
  // radicand scale of the boundary length and scale of the boundary numerator
  localparam int unsigned LenShift = 16;
  localparam int unsigned NumShift = 8;

  // on a hit, dx*dx + dy*dy stays below (2^(RadW+1))^2 + 2^(FracBits+1)
  localparam int unsigned SumW  = 2 * (RadW + 1) + 1;
  localparam int unsigned LenW  = (SumW + LenShift + 1) / 2;
  localparam int unsigned MagW  = RadW + 2;
  localparam int unsigned ProdW = RadW + MagW;
  localparam int unsigned DivW  = LenW + 1;
  localparam int unsigned QuoW  = RadW + 1;
  localparam int unsigned DvdW  = DivW + QuoW;

  localparam int unsigned CfgIdxW = 3;

  typedef enum logic [CfgIdxW-1:0] {
    CfgFirstOx   = 3'd0,
    CfgFirstOy   = 3'd1,
    CfgFirstRad  = 3'd2,
    CfgSecondOx  = 3'd3,
    CfgSecondOy  = 3'd4,
    CfgSecondRad = 3'd5,
    CfgSecondEn  = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    logic is_hit;
    logic which;
    logic spark_v;
    logic in_circle;
    logic dx_neg;
    logic dy_neg;
  } flags_t;

endpackage

### sv/chc_front.sv
module chc_front #(
  parameter int unsigned FRAC_BITS   = chc_pkg::FracBits,
  parameter int unsigned COORD_WIDTH = chc_pkg::CoordW
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  output logic                          ready_o,
  input  logic signed [COORD_WIDTH-1:0] entity_x_i,
  input  logic signed [COORD_WIDTH-1:0] entity_y_i,
  input  logic                          facing_right_i,
  input  logic signed [COORD_WIDTH-1:0] probe_x_i,
  input  logic signed [COORD_WIDTH-1:0] probe_y_i,
  input  logic [chc_pkg::RadW-1:0]      probe_radius_i,
  input  logic                          damaging_i,
  input  logic signed [COORD_WIDTH-1:0] ox1_i,
  input  logic signed [COORD_WIDTH-1:0] oy1_i,
  input  logic [chc_pkg::RadW-1:0]      rad1_i,
  input  logic signed [COORD_WIDTH-1:0] ox2_i,
  input  logic signed [COORD_WIDTH-1:0] oy2_i,
  input  logic [chc_pkg::RadW-1:0]      rad2_i,
  input  logic                          en2_i,
  output logic                          valid_o,
  input  logic                          ready_i,
  output chc_pkg::flags_t               flags_o,
  output logic [COORD_WIDTH-1:0]        cx_o,
  output logic [COORD_WIDTH-1:0]        cy_o,
  output logic [COORD_WIDTH-1:0]        px_o,
  output logic [COORD_WIDTH-1:0]        py_o,
  output logic [chc_pkg::RadW-1:0]      rad_o,
  output logic [chc_pkg::MagW-1:0]      ax_o,
  output logic [chc_pkg::MagW-1:0]      ay_o,
  output logic [chc_pkg::SumW-1:0]      sum_o
);
  import chc_pkg::*;

  localparam int unsigned AW   = COORD_WIDTH + 2;
  localparam int unsigned DW   = COORD_WIDTH + 3;
  localparam int unsigned SqW  = 2 * AW;
  localparam int unsigned RsW  = RadW + 1;
  localparam int unsigned Rs2W = 2 * RsW;
  localparam int unsigned RrW  = 2 * RadW;
  localparam logic signed [AW-1:0] Unit = AW'(1) << FRAC_BITS;

  logic v1_q, v2_q, v3_q, r1, r2, r3;

  assign r3      = !v3_q || ready_i;
  assign r2      = !v2_q || r3;
  assign r1      = !v1_q || r2;
  assign ready_o = r1;
  assign valid_o = v3_q;

  // stage 1: centres, distances, radius sums
  logic signed [AW-1:0]          cx_d [2];
  logic signed [AW-1:0]          cy_d [2];
  logic signed [DW-1:0]          dx_d [2];
  logic signed [DW-1:0]          dy_d [2];
  logic signed [COORD_WIDTH-1:0] ox [2];
  logic signed [COORD_WIDTH-1:0] oy [2];
  logic [RadW-1:0]               rad [2];

  assign ox[0]  = ox1_i;
  assign ox[1]  = ox2_i;
  assign oy[0]  = oy1_i;
  assign oy[1]  = oy2_i;
  assign rad[0] = rad1_i;
  assign rad[1] = rad2_i;

  always_comb begin
    for (int k = 0; k < 2; k++) begin
      cx_d[k] = AW'(entity_x_i) + (facing_right_i ? AW'(ox[k]) + Unit : -AW'(ox[k]));
      cy_d[k] = AW'(entity_y_i) + AW'(oy[k]);
      dx_d[k] = DW'(probe_x_i) - DW'(cx_d[k]);
      dy_d[k] = DW'(probe_y_i) - DW'(cy_d[k]);
    end
  end

  logic signed [DW-1:0]   dx1_q [2];
  logic signed [DW-1:0]   dy1_q [2];
  logic [RsW-1:0]         rs1_q [2];
  logic [COORD_WIDTH-1:0] cx1_q [2];
  logic [COORD_WIDTH-1:0] cy1_q [2];
  logic [COORD_WIDTH-1:0] px1_q, py1_q;
  logic                   dmg1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (r1) begin
      v1_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (r1 && valid_i) begin
      for (int k = 0; k < 2; k++) begin
        dx1_q[k] <= dx_d[k];
        dy1_q[k] <= dy_d[k];
        rs1_q[k] <= RsW'(rad[k]) + RsW'(probe_radius_i);
        cx1_q[k] <= cx_d[k][COORD_WIDTH-1:0];
        cy1_q[k] <= cy_d[k][COORD_WIDTH-1:0];
      end
      px1_q  <= probe_x_i;
      py1_q  <= probe_y_i;
      dmg1_q <= damaging_i;
    end
  end

  // stage 2: squares
  logic signed [2*DW-1:0] px_sq [2];
  logic signed [2*DW-1:0] py_sq [2];
  logic signed [DW-1:0]   mx [2];
  logic signed [DW-1:0]   my [2];

  always_comb begin
    for (int k = 0; k < 2; k++) begin
      px_sq[k] = dx1_q[k] * dx1_q[k];
      py_sq[k] = dy1_q[k] * dy1_q[k];
      mx[k]    = dx1_q[k][DW-1] ? -dx1_q[k] : dx1_q[k];
      my[k]    = dy1_q[k][DW-1] ? -dy1_q[k] : dy1_q[k];
    end
  end

  logic [SqW-1:0]         sqx2_q [2];
  logic [SqW-1:0]         sqy2_q [2];
  logic [Rs2W-1:0]        rs2_q [2];
  logic [RrW-1:0]         rr2_q [2];
  logic [MagW-1:0]        ax2_q [2];
  logic [MagW-1:0]        ay2_q [2];
  logic                   dxn2_q [2];
  logic                   dyn2_q [2];
  logic [COORD_WIDTH-1:0] cx2_q [2];
  logic [COORD_WIDTH-1:0] cy2_q [2];
  logic [COORD_WIDTH-1:0] px2_q, py2_q;
  logic                   dmg2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (r2) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (r2 && v1_q) begin
      for (int k = 0; k < 2; k++) begin
        sqx2_q[k] <= px_sq[k][SqW-1:0];
        sqy2_q[k] <= py_sq[k][SqW-1:0];
        rs2_q[k]  <= rs1_q[k] * rs1_q[k];
        rr2_q[k]  <= rad[k] * rad[k];
        ax2_q[k]  <= mx[k][MagW-1:0];
        ay2_q[k]  <= my[k][MagW-1:0];
        dxn2_q[k] <= dx1_q[k][DW-1];
        dyn2_q[k] <= dy1_q[k][DW-1];
        cx2_q[k]  <= cx1_q[k];
        cy2_q[k]  <= cy1_q[k];
      end
      px2_q  <= px1_q;
      py2_q  <= py1_q;
      dmg2_q <= dmg1_q;
    end
  end

  // stage 3: overlap and inside tests, sphere select
  logic [SqW:0]    shsum [2];
  logic [SumW-1:0] fsum [2];
  logic            hit [2];
  logic            ins [2];
  logic            hit_any, sel;
  flags_t          flags_d;

  always_comb begin
    for (int k = 0; k < 2; k++) begin
      shsum[k] = (SqW+1)'(sqx2_q[k] >> FRAC_BITS) + (SqW+1)'(sqy2_q[k] >> FRAC_BITS);
      hit[k]   = shsum[k] <= (SqW+1)'(rs2_q[k] >> FRAC_BITS);
      ins[k]   = shsum[k] <= (SqW+1)'(rr2_q[k] >> FRAC_BITS);
      fsum[k]  = sqx2_q[k][SumW-1:0] + sqy2_q[k][SumW-1:0];
    end
    hit_any           = hit[0] || (en2_i && hit[1]);
    sel               = !hit[0];
    flags_d.is_hit    = hit_any;
    flags_d.which     = hit_any && !hit[0];
    flags_d.spark_v   = hit_any && dmg2_q;
    flags_d.in_circle = ins[sel];
    flags_d.dx_neg    = dxn2_q[sel];
    flags_d.dy_neg    = dyn2_q[sel];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (r3) begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (r3 && v2_q) begin
      flags_o <= flags_d;
      cx_o    <= cx2_q[sel];
      cy_o    <= cy2_q[sel];
      px_o    <= px2_q;
      py_o    <= py2_q;
      rad_o   <= rad[sel];
      ax_o    <= ax2_q[sel];
      ay_o    <= ay2_q[sel];
      sum_o   <= fsum[sel];
    end
  end

endmodule

### sv/chc_sqrt_cell.sv
module chc_sqrt_cell #(
  parameter int unsigned SIDE_W = 1
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         valid_i,
  output logic                         ready_o,
  output logic                         valid_o,
  input  logic                         ready_i,
  input  chc_pkg::flags_t              flags_i,
  output chc_pkg::flags_t              flags_o,
  input  logic [SIDE_W-1:0]            side_i,
  output logic [SIDE_W-1:0]            side_o,
  input  logic [2*chc_pkg::LenW-1:0]   rcand_i,
  output logic [2*chc_pkg::LenW-1:0]   rcand_o,
  input  logic [chc_pkg::LenW+2:0]     rem_i,
  output logic [chc_pkg::LenW+2:0]     rem_o,
  input  logic [chc_pkg::LenW-1:0]     root_i,
  output logic [chc_pkg::LenW-1:0]     root_o
);
  import chc_pkg::*;

  logic             valid_q;
  logic [LenW+2:0]  rem_sh, trial;
  logic             ge;

  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;

  // one root bit: bring down two radicand bits, try (root << 2) | 1
  always_comb begin
    rem_sh = {rem_i[LenW:0], rcand_i[2*LenW-1 -: 2]};
    trial  = {1'b0, root_i, 2'b01};
    ge     = rem_sh >= trial;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      flags_o <= flags_i;
      side_o  <= side_i;
      rcand_o <= {rcand_i[2*LenW-3:0], 2'b00};
      rem_o   <= ge ? rem_sh - trial : rem_sh;
      root_o  <= {root_i[LenW-2:0], ge};
    end
  end

endmodule

### sv/chc_scale.sv
module chc_scale #(
  parameter int unsigned SIDE_W = 1
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           valid_i,
  output logic                           ready_o,
  output logic                           valid_o,
  input  logic                           ready_i,
  input  chc_pkg::flags_t                flags_i,
  output chc_pkg::flags_t                flags_o,
  input  logic [SIDE_W-1:0]              side_i,
  output logic [SIDE_W-1:0]              side_o,
  input  logic [chc_pkg::RadW-1:0]       rad_i,
  input  logic [chc_pkg::MagW-1:0]       ax_i,
  input  logic [chc_pkg::MagW-1:0]       ay_i,
  input  logic [chc_pkg::LenW-1:0]       len_i,
  output logic [1:0][chc_pkg::DivW-1:0]  rem_o,
  output logic [1:0][chc_pkg::QuoW-1:0]  low_o,
  output logic [chc_pkg::DivW-1:0]       dv_o
);
  import chc_pkg::*;

  logic v1_q, v2_q, r1, r2;

  assign r2      = !v2_q || ready_i;
  assign r1      = !v1_q || r2;
  assign ready_o = r1;
  assign valid_o = v2_q;

  // stage 1: radius times axis distance
  logic [1:0][ProdW-1:0] prod_q;
  logic [LenW-1:0]       len_q;
  flags_t                flags_q;
  logic [SIDE_W-1:0]     side_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (r1) begin
        v1_q <= valid_i;
      end
      if (r2) begin
        v2_q <= v1_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (r1 && valid_i) begin
      prod_q[0] <= rad_i * ax_i;
      prod_q[1] <= rad_i * ay_i;
      len_q     <= len_i;
      flags_q   <= flags_i;
      side_q    <= side_i;
    end
  end

  // stage 2: dividend 2*num + len with num = prod * 256, divisor 2*len
  logic [1:0][DvdW-1:0] dvd;

  always_comb begin
    for (int k = 0; k < 2; k++) begin
      dvd[k] = (DvdW'(prod_q[k]) << (NumShift + 1)) + DvdW'(len_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (r2 && v1_q) begin
      for (int k = 0; k < 2; k++) begin
        rem_o[k] <= dvd[k][DvdW-1:QuoW];
        low_o[k] <= dvd[k][QuoW-1:0];
      end
      dv_o    <= {len_q, 1'b0};
      flags_o <= flags_q;
      side_o  <= side_q;
    end
  end

endmodule

### sv/chc_div_cell.sv
module chc_div_cell #(
  parameter int unsigned SIDE_W = 1
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           valid_i,
  output logic                           ready_o,
  output logic                           valid_o,
  input  logic                           ready_i,
  input  chc_pkg::flags_t                flags_i,
  output chc_pkg::flags_t                flags_o,
  input  logic [SIDE_W-1:0]              side_i,
  output logic [SIDE_W-1:0]              side_o,
  input  logic [chc_pkg::DivW-1:0]       dv_i,
  output logic [chc_pkg::DivW-1:0]       dv_o,
  input  logic [1:0][chc_pkg::DivW-1:0]  rem_i,
  output logic [1:0][chc_pkg::DivW-1:0]  rem_o,
  input  logic [1:0][chc_pkg::QuoW-1:0]  low_i,
  output logic [1:0][chc_pkg::QuoW-1:0]  low_o,
  input  logic [1:0][chc_pkg::QuoW-1:0]  q_i,
  output logic [1:0][chc_pkg::QuoW-1:0]  q_o
);
  import chc_pkg::*;

  logic              valid_q;
  logic [DivW:0]     rem_sh [2];
  logic [DivW:0]     rem_sub [2];
  logic              ge [2];

  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;

  // one quotient bit per axis, restoring
  always_comb begin
    for (int k = 0; k < 2; k++) begin
      rem_sh[k]  = {rem_i[k], low_i[k][QuoW-1]};
      ge[k]      = rem_sh[k] >= {1'b0, dv_i};
      rem_sub[k] = rem_sh[k] - {1'b0, dv_i};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      for (int k = 0; k < 2; k++) begin
        rem_o[k] <= ge[k] ? rem_sub[k][DivW-1:0] : rem_sh[k][DivW-1:0];
        low_o[k] <= {low_i[k][QuoW-2:0], 1'b0};
        q_o[k]   <= {q_i[k][QuoW-2:0], ge[k]};
      end
      dv_o    <= dv_i;
      flags_o <= flags_i;
      side_o  <= side_i;
    end
  end

endmodule

### sv/circle_hitbox_collision.sv
// channel   direction  handshake                  payload
// input     in         in_valid_i / in_ready_o    entity, facing, probe circle, damaging
// result    out        out_valid_o / out_ready_i  hit, sphere, spark point, push
// config    in         cfg_we_i (no wait)         cfg_idx_i, cfg_data_i
//
// one transaction per cycle sustained while results are taken; data passes the front
// end, square-root cell row (one root bit per cell), scale stage, divider cell row
// (one quotient bit per cell) and result register. every stage has its own valid and
// moves when the next is free, so bubbles close up and a held result stops intake
// only once every stage is full. reset clears valid bits and config registers only.
module circle_hitbox_collision #(
  parameter int unsigned FRAC_BITS   = chc_pkg::FracBits,
  parameter int unsigned COORD_WIDTH = chc_pkg::CoordW
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [chc_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  logic [COORD_WIDTH-1:0]          cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic signed [COORD_WIDTH-1:0]   entity_x_i,
  input  logic signed [COORD_WIDTH-1:0]   entity_y_i,
  input  logic                            facing_right_i,
  input  logic signed [COORD_WIDTH-1:0]   probe_x_i,
  input  logic signed [COORD_WIDTH-1:0]   probe_y_i,
  input  logic [chc_pkg::RadW-1:0]        probe_radius_i,
  input  logic                            damaging_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic                            is_hit_o,
  output logic                            which_sphere_o,
  output logic                            spark_valid_o,
  output logic signed [COORD_WIDTH-1:0]   spark_x_o,
  output logic signed [COORD_WIDTH-1:0]   spark_y_o,
  output logic                            push_right_o
);
  import chc_pkg::*;

  localparam int unsigned CW    = COORD_WIDTH;
  localparam int unsigned SideS = 4 * CW + RadW + 2 * MagW;
  localparam int unsigned SideD = 4 * CW;

  // configuration registers
  logic signed [CW-1:0] ox1_q, oy1_q, ox2_q, oy2_q;
  logic [RadW-1:0]      rad1_q, rad2_q;
  logic                 en2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ox1_q  <= '0;
      oy1_q  <= '0;
      rad1_q <= '0;
      ox2_q  <= '0;
      oy2_q  <= '0;
      rad2_q <= '0;
      en2_q  <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CfgFirstOx:   ox1_q  <= cfg_data_i;
        CfgFirstOy:   oy1_q  <= cfg_data_i;
        CfgFirstRad:  rad1_q <= cfg_data_i[RadW-1:0];
        CfgSecondOx:  ox2_q  <= cfg_data_i;
        CfgSecondOy:  oy2_q  <= cfg_data_i;
        CfgSecondRad: rad2_q <= cfg_data_i[RadW-1:0];
        CfgSecondEn:  en2_q  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // hit test front end
  logic            f_valid, f_ready;
  flags_t          f_flags;
  logic [CW-1:0]   f_cx, f_cy, f_px, f_py;
  logic [RadW-1:0] f_rad;
  logic [MagW-1:0] f_ax, f_ay;
  logic [SumW-1:0] f_sum;

  chc_front #(
    .FRAC_BITS  (FRAC_BITS),
    .COORD_WIDTH(COORD_WIDTH)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .valid_i       (in_valid_i),
    .ready_o       (in_ready_o),
    .entity_x_i    (entity_x_i),
    .entity_y_i    (entity_y_i),
    .facing_right_i(facing_right_i),
    .probe_x_i     (probe_x_i),
    .probe_y_i     (probe_y_i),
    .probe_radius_i(probe_radius_i),
    .damaging_i    (damaging_i),
    .ox1_i         (ox1_q),
    .oy1_i         (oy1_q),
    .rad1_i        (rad1_q),
    .ox2_i         (ox2_q),
    .oy2_i         (oy2_q),
    .rad2_i        (rad2_q),
    .en2_i         (en2_q),
    .valid_o       (f_valid),
    .ready_i       (f_ready),
    .flags_o       (f_flags),
    .cx_o          (f_cx),
    .cy_o          (f_cy),
    .px_o          (f_px),
    .py_o          (f_py),
    .rad_o         (f_rad),
    .ax_o          (f_ax),
    .ay_o          (f_ay),
    .sum_o         (f_sum)
  );

  // square-root cell row: length = isqrt(sum << 16)
  logic                s_valid [LenW+1];
  logic                s_ready [LenW+1];
  flags_t              s_flags [LenW+1];
  logic [SideS-1:0]    s_side  [LenW+1];
  logic [2*LenW-1:0]   s_rcand [LenW+1];
  logic [LenW+2:0]     s_rem   [LenW+1];
  logic [LenW-1:0]     s_root  [LenW+1];

  assign s_valid[0] = f_valid;
  assign f_ready    = s_ready[0];
  assign s_flags[0] = f_flags;
  assign s_side[0]  = {f_cx, f_cy, f_px, f_py, f_rad, f_ax, f_ay};
  assign s_rcand[0] = (2*LenW)'({f_sum, LenShift'(0)});
  assign s_rem[0]   = '0;
  assign s_root[0]  = '0;

  for (genvar i = 0; i < LenW; i++) begin : g_sqrt
    chc_sqrt_cell #(
      .SIDE_W(SideS)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .valid_i(s_valid[i]),
      .ready_o(s_ready[i]),
      .valid_o(s_valid[i+1]),
      .ready_i(s_ready[i+1]),
      .flags_i(s_flags[i]),
      .flags_o(s_flags[i+1]),
      .side_i (s_side[i]),
      .side_o (s_side[i+1]),
      .rcand_i(s_rcand[i]),
      .rcand_o(s_rcand[i+1]),
      .rem_i  (s_rem[i]),
      .rem_o  (s_rem[i+1]),
      .root_i (s_root[i]),
      .root_o (s_root[i+1])
    );
  end

  logic [SideD-1:0] s_pass;
  logic [RadW-1:0]  s_rad;
  logic [MagW-1:0]  s_ax, s_ay;

  assign {s_pass, s_rad, s_ax, s_ay} = s_side[LenW];

  // numerator scaling and divider set-up
  logic d_valid [QuoW+1];
  logic d_ready [QuoW+1];
  flags_t                d_flags [QuoW+1];
  logic [SideD-1:0]      d_side  [QuoW+1];
  logic [DivW-1:0]       d_dv    [QuoW+1];
  logic [1:0][DivW-1:0]  d_rem   [QuoW+1];
  logic [1:0][QuoW-1:0]  d_low   [QuoW+1];
  logic [1:0][QuoW-1:0]  d_q     [QuoW+1];

  chc_scale #(
    .SIDE_W(SideD)
  ) u_scale (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(s_valid[LenW]),
    .ready_o(s_ready[LenW]),
    .valid_o(d_valid[0]),
    .ready_i(d_ready[0]),
    .flags_i(s_flags[LenW]),
    .flags_o(d_flags[0]),
    .side_i (s_pass),
    .side_o (d_side[0]),
    .rad_i  (s_rad),
    .ax_i   (s_ax),
    .ay_i   (s_ay),
    .len_i  (s_root[LenW]),
    .rem_o  (d_rem[0]),
    .low_o  (d_low[0]),
    .dv_o   (d_dv[0])
  );

  assign d_q[0] = '0;

  // divider cell row: offset = (2*num + len) / (2*len), both axes
  for (genvar i = 0; i < QuoW; i++) begin : g_div
    chc_div_cell #(
      .SIDE_W(SideD)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .valid_i(d_valid[i]),
      .ready_o(d_ready[i]),
      .valid_o(d_valid[i+1]),
      .ready_i(d_ready[i+1]),
      .flags_i(d_flags[i]),
      .flags_o(d_flags[i+1]),
      .side_i (d_side[i]),
      .side_o (d_side[i+1]),
      .dv_i   (d_dv[i]),
      .dv_o   (d_dv[i+1]),
      .rem_i  (d_rem[i]),
      .rem_o  (d_rem[i+1]),
      .low_i  (d_low[i]),
      .low_o  (d_low[i+1]),
      .q_i    (d_q[i]),
      .q_o    (d_q[i+1])
    );
  end

  // spark point and result register
  flags_t          e_flags;
  logic [CW-1:0]   e_cx, e_cy, e_px, e_py;
  logic [QuoW-1:0] qx, qy;
  logic [CW-1:0]   sx_d, sy_d;
  logic            push_d;
  logic            out_valid_q;

  assign e_flags = d_flags[QuoW];
  assign {e_cx, e_cy, e_px, e_py} = d_side[QuoW];
  assign qx = d_q[QuoW][0];
  assign qy = d_q[QuoW][1];

  always_comb begin
    sx_d   = e_flags.dx_neg ? e_cx - CW'(qx) : e_cx + CW'(qx);
    sy_d   = e_flags.dy_neg ? e_cy - CW'(qy) : e_cy + CW'(qy);
    push_d = !(e_flags.dx_neg && (qx != '0));
    if (e_flags.in_circle) begin
      sx_d   = e_px;
      sy_d   = e_py;
      push_d = !e_flags.dx_neg;
    end
    if (!e_flags.spark_v) begin
      sx_d   = '0;
      sy_d   = '0;
      push_d = 1'b0;
    end
  end

  assign d_ready[QuoW] = !out_valid_q || out_ready_i;
  assign out_valid_o   = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (d_ready[QuoW]) begin
      out_valid_q <= d_valid[QuoW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (d_ready[QuoW] && d_valid[QuoW]) begin
      is_hit_o       <= e_flags.is_hit;
      which_sphere_o <= e_flags.which;
      spark_valid_o  <= e_flags.spark_v;
      spark_x_o      <= sx_d;
      spark_y_o      <= sy_d;
      push_right_o   <= push_d;
    end
  end

endmodule
